>>> sv/ctam_pkg.sv
`timescale 1ns / 1ps
package ctam_pkg;

   localparam int MAX_FACE_SIZE        = 4096;
   localparam int COMPONENTS_PER_TEXEL = 4;
   localparam int SIZE_W               = 13;
   localparam int COORD_W              = 12;
   localparam int FRAC_W               = 8;
   localparam int ADDR_W               = 29;
   localparam int DIR_W                = 16;
   localparam int PROD_W               = 29;
   localparam int SQ_W                 = 25;
   localparam int DEN_W                = 17;
   localparam int QUO_W                = SIZE_W + FRAC_W;
   localparam int DIV_STEPS            = QUO_W;
   localparam int FIFO_DEPTH           = 4;

   typedef enum logic {
      CSR_FACE_SIZE   = 1'b0,
      CSR_FILTER_MODE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   typedef struct packed {
      logic [2:0]        face;
      logic [PROD_W-1:0] prod_s;
      logic [PROD_W-1:0] prod_t;
      logic [DIR_W-1:0]  major;
      logic [SQ_W-1:0]   sq;
      logic [SIZE_W-1:0] size;
      logic              bil;
   } work_type;

   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [SIZE_W-1:0] low;
      logic [QUO_W-1:0]  quo;
   } div_state_type;

   typedef struct packed {
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      logic [FRAC_W-1:0]  frac;
   } axis_type;

   function automatic div_state_type div_step(div_state_type d, logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      div_state_type  r;
      trial = {d.rem, d.low[SIZE_W-1]};
      r.low = {d.low[SIZE_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         r.rem = DEN_W'(trial - {1'b0, den});
         r.quo = {d.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = trial[DEN_W-1:0];
         r.quo = {d.quo[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic axis_type axis_clamp(logic [QUO_W-1:0] quo, logic [COORD_W-1:0] top,
                                           logic bil);
      logic [SIZE_W-1:0] q;
      axis_type          a;
      q = quo[QUO_W-1:FRAC_W];
      a.frac = '0;
      if (!bil) begin
         a.lo = (q > {1'b0, top}) ? top : q[COORD_W-1:0];
      end else if (q >= {1'b0, top}) begin
         a.lo = top;
      end else begin
         a.lo   = q[COORD_W-1:0];
         a.frac = quo[FRAC_W-1:0];
      end
      if (!bil || a.lo == top) begin
         a.hi = bil ? top : a.lo;
      end else begin
         a.hi = a.lo + COORD_W'(1);
      end
      return a;
   endfunction

endpackage

>>> sv/ctam_req_if.sv
`timescale 1ns / 1ps
interface ctam_req_if;
   logic                      valid;
   logic                      ready;
   logic signed [15:0]        dir_x;
   logic signed [15:0]        dir_y;
   logic signed [15:0]        dir_z;
   modport source (output valid, dir_x, dir_y, dir_z, input ready);
   modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

>>> sv/ctam_rsp_if.sv
`timescale 1ns / 1ps
interface ctam_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  face;
   logic [11:0] x_low;
   logic [11:0] y_low;
   logic [11:0] x_high;
   logic [11:0] y_high;
   logic [7:0]  frac_x;
   logic [7:0]  frac_y;
   logic [28:0] addr_ll;
   logic [28:0] addr_hl;
   logic [28:0] addr_lh;
   logic [28:0] addr_hh;
   modport source (output valid, face, x_low, y_low, x_high, y_high, frac_x, frac_y,
                   addr_ll, addr_hl, addr_lh, addr_hh, input ready);
   modport sink (input valid, face, x_low, y_low, x_high, y_high, frac_x, frac_y,
                 addr_ll, addr_hl, addr_lh, addr_hh, output ready);
endinterface

>>> sv/ctam_front.sv
`timescale 1ns / 1ps
module ctam_front (
   input  logic                          clock,
   input  logic                          reset,
   ctam_req_if.sink                      req_chan,
   input  logic [ctam_pkg::SIZE_W-1:0]   size,
   input  logic                          bil,
   output logic                          push_valid,
   output ctam_pkg::work_type            push_data,
   input  logic                          push_full
);
   import ctam_pkg::*;

   typedef struct packed {
      logic [2:0]        face;
      logic signed [16:0] s;
      logic signed [16:0] t;
      logic [DIR_W-1:0]  major;
      logic [SIZE_W-1:0] size;
      logic              bil;
   } class_type;

   logic              a_valid_ff;
   class_type         a_ff;
   class_type         a_in;
   logic signed [16:0] xe, ye, ze;
   logic [16:0]       ax, ay, az;
   logic [16:0]       n_s, n_t;
   logic signed [17:0] sum_s, sum_t;

   assign req_chan.ready = !a_valid_ff || !push_full;

   always_comb begin
      xe = {req_chan.dir_x[15], req_chan.dir_x};
      ye = {req_chan.dir_y[15], req_chan.dir_y};
      ze = {req_chan.dir_z[15], req_chan.dir_z};
      ax = xe[16] ? 17'(-xe) : 17'(xe);
      ay = ye[16] ? 17'(-ye) : 17'(ye);
      az = ze[16] ? 17'(-ze) : 17'(ze);
      a_in.size = size;
      a_in.bil  = bil;
      if (ax >= ay && ax >= az) begin
         a_in.face  = xe[16] ? FACE_NEG_X : FACE_POS_X;
         a_in.s     = xe[16] ? ze : -ze;
         a_in.t     = -ye;
         a_in.major = ax[DIR_W-1:0];
      end else if (ay >= az) begin
         a_in.face  = ye[16] ? FACE_NEG_Y : FACE_POS_Y;
         a_in.s     = xe;
         a_in.t     = ye[16] ? -ze : ze;
         a_in.major = ay[DIR_W-1:0];
      end else begin
         a_in.face  = ze[16] ? FACE_NEG_Z : FACE_POS_Z;
         a_in.s     = ze[16] ? -xe : xe;
         a_in.t     = -ye;
         a_in.major = az[DIR_W-1:0];
      end
      if (a_in.major == '0) begin
         a_in.s     = '0;
         a_in.t     = '0;
         a_in.major = DIR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         a_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         a_ff <= a_in;
      end
   end

   always_comb begin
      sum_s = 18'(a_ff.s) + $signed({2'b00, a_ff.major});
      sum_t = 18'(a_ff.t) + $signed({2'b00, a_ff.major});
      n_s   = sum_s[16:0];
      n_t   = sum_t[16:0];
      push_valid       = a_valid_ff;
      push_data.face   = a_ff.face;
      push_data.prod_s = PROD_W'(n_s) * PROD_W'(a_ff.size);
      push_data.prod_t = PROD_W'(n_t) * PROD_W'(a_ff.size);
      push_data.major  = a_ff.major;
      push_data.sq     = SQ_W'(a_ff.size) * SQ_W'(a_ff.size);
      push_data.size   = a_ff.size;
      push_data.bil    = a_ff.bil;
   end

endmodule

>>> sv/ctam_fifo.sv
`timescale 1ns / 1ps
module ctam_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ctam_pkg::work_type  push_data,
   output logic                push_full,
   input  logic                pop,
   output logic                pop_valid,
   output ctam_pkg::work_type  pop_data
);
   import ctam_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   work_type           mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [PTR_W:0]     count_ff;
   logic               do_push, do_pop;

   assign push_full = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (PTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (PTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> sv/ctam_back.sv
`timescale 1ns / 1ps
module ctam_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  ctam_pkg::work_type pop_data,
   output logic               pop,
   ctam_rsp_if.source         rsp_chan
);
   import ctam_pkg::*;

   localparam int LAST = DIV_STEPS + 3;

   typedef struct packed {
      logic [2:0]         face;
      logic [ADDR_W-1:0]  base;
      logic [SIZE_W-1:0]  size;
      logic [COORD_W-1:0] top;
      logic [DEN_W-1:0]   den;
      logic               bil;
   } side_type;

   typedef struct packed {
      side_type           side;
      axis_type           ax;
      axis_type           ay;
   } clamp_type;

   typedef struct packed {
      side_type           side;
      axis_type           ax;
      axis_type           ay;
      logic [SQ_W-1:0]    row_l;
      logic [SQ_W-1:0]    row_h;
   } row_type;

   typedef struct packed {
      logic [2:0]         face;
      axis_type           ax;
      axis_type           ay;
      logic [ADDR_W-1:0]  ll, hl, lh, hh;
   } out_type;

   logic [LAST:0]   v_ff;
   logic            adv;
   div_state_type   ds_ff [DIV_STEPS+1];
   div_state_type   dt_ff [DIV_STEPS+1];
   side_type        side_ff [DIV_STEPS+1];
   clamp_type       cl_ff;
   row_type         row_ff;
   out_type         out_ff;
   div_state_type   ds_in, dt_in;
   side_type        side_in;
   logic [PROD_W-1:0] num_s, num_t;
   logic [ADDR_W-1:0] sq_w;

   assign adv = !v_ff[LAST] || rsp_chan.ready;
   assign pop = adv && pop_valid;

   always_comb begin
      num_s = pop_data.prod_s;
      num_t = pop_data.prod_t;
      if (pop_data.bil) begin
         num_s = (pop_data.prod_s > PROD_W'(pop_data.major)) ?
                 pop_data.prod_s - PROD_W'(pop_data.major) : '0;
         num_t = (pop_data.prod_t > PROD_W'(pop_data.major)) ?
                 pop_data.prod_t - PROD_W'(pop_data.major) : '0;
      end
      ds_in.rem = DEN_W'(num_s[PROD_W-1:SIZE_W]);
      ds_in.low = num_s[SIZE_W-1:0];
      ds_in.quo = '0;
      dt_in.rem = DEN_W'(num_t[PROD_W-1:SIZE_W]);
      dt_in.low = num_t[SIZE_W-1:0];
      dt_in.quo = '0;
      sq_w         = ADDR_W'(pop_data.sq);
      side_in.face = pop_data.face;
      side_in.base = (pop_data.face[0] ? sq_w : '0) +
                     (pop_data.face[1] ? {sq_w[ADDR_W-2:0], 1'b0} : '0) +
                     (pop_data.face[2] ? {sq_w[ADDR_W-3:0], 2'b00} : '0);
      side_in.size = pop_data.size;
      side_in.top  = COORD_W'(pop_data.size - SIZE_W'(1));
      side_in.den  = {pop_data.major, 1'b0};
      side_in.bil  = pop_data.bil;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAST-1:0], pop_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds_ff[0]   <= ds_in;
         dt_ff[0]   <= dt_in;
         side_ff[0] <= side_in;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            ds_ff[k]   <= div_step(ds_ff[k-1], side_ff[k-1].den);
            dt_ff[k]   <= div_step(dt_ff[k-1], side_ff[k-1].den);
            side_ff[k] <= side_ff[k-1];
         end
         cl_ff.side <= side_ff[DIV_STEPS];
         cl_ff.ax   <= axis_clamp(ds_ff[DIV_STEPS].quo, side_ff[DIV_STEPS].top,
                                  side_ff[DIV_STEPS].bil);
         cl_ff.ay   <= axis_clamp(dt_ff[DIV_STEPS].quo, side_ff[DIV_STEPS].top,
                                  side_ff[DIV_STEPS].bil);
         row_ff.side  <= cl_ff.side;
         row_ff.ax    <= cl_ff.ax;
         row_ff.ay    <= cl_ff.ay;
         row_ff.row_l <= SQ_W'(cl_ff.ay.lo) * SQ_W'(cl_ff.side.size);
         row_ff.row_h <= SQ_W'(cl_ff.ay.hi) * SQ_W'(cl_ff.side.size);
         out_ff.face <= row_ff.side.face;
         out_ff.ax   <= row_ff.ax;
         out_ff.ay   <= row_ff.ay;
         out_ff.ll   <= ADDR_W'((row_ff.side.base + ADDR_W'(row_ff.row_l)
                        + ADDR_W'(row_ff.ax.lo)) * COMPONENTS_PER_TEXEL);
         out_ff.hl   <= ADDR_W'((row_ff.side.base + ADDR_W'(row_ff.row_l)
                        + ADDR_W'(row_ff.ax.hi)) * COMPONENTS_PER_TEXEL);
         out_ff.lh   <= ADDR_W'((row_ff.side.base + ADDR_W'(row_ff.row_h)
                        + ADDR_W'(row_ff.ax.lo)) * COMPONENTS_PER_TEXEL);
         out_ff.hh   <= ADDR_W'((row_ff.side.base + ADDR_W'(row_ff.row_h)
                        + ADDR_W'(row_ff.ax.hi)) * COMPONENTS_PER_TEXEL);
      end
   end

   assign rsp_chan.valid   = v_ff[LAST];
   assign rsp_chan.face    = out_ff.face;
   assign rsp_chan.x_low   = out_ff.ax.lo;
   assign rsp_chan.x_high  = out_ff.ax.hi;
   assign rsp_chan.frac_x  = out_ff.ax.frac;
   assign rsp_chan.y_low   = out_ff.ay.lo;
   assign rsp_chan.y_high  = out_ff.ay.hi;
   assign rsp_chan.frac_y  = out_ff.ay.frac;
   assign rsp_chan.addr_ll = out_ff.ll;
   assign rsp_chan.addr_hl = out_ff.hl;
   assign rsp_chan.addr_lh = out_ff.lh;
   assign rsp_chan.addr_hh = out_ff.hh;

endmodule

>>> sv/cubemap_texel_address_unit.sv
`timescale 1ns / 1ps
// Cube-map texel address unit.
// A transaction on the request channel carries one direction vector in
// signed 2.14 fixed point. For each one the unit returns exactly one
// transaction on the response channel with the selected face, the texel
// column and row pair, the blend fractions and four element addresses.
// The user must write the face size and filter mode through the CSR port
// only while no transaction is in flight; the block does not enforce it.
// They take effect for later requests. The front end classifies the vector
// and forms the scaled numerators; a four-entry queue separates it from
// the back end, which runs a pipelined divider producing one quotient
// bit per stage, then clamps and forms the addresses. In steady state,
// while the receiver does not stall, one request is accepted every cycle.
// When the receiver stalls, the back-end pipeline holds, the queue fills,
// and only then does the request ready drop. Reset empties the pipeline
// and queue and sets the face size to 256 and the filter mode to nearest.
module cubemap_texel_address_unit (
   input  logic                         clock,
   input  logic                         reset,
   ctam_req_if.sink                     req_chan,
   ctam_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [ctam_pkg::SIZE_W-1:0]  csr_write_data
);
   import ctam_pkg::*;

   logic [SIZE_W-1:0] face_size_ff;
   logic              filter_mode_ff;
   logic [SIZE_W-1:0] size_eff;
   logic              push_valid, push_full, pop, pop_valid;
   work_type          push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff   <= SIZE_W'(256);
         filter_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FACE_SIZE:   face_size_ff   <= csr_write_data;
            CSR_FILTER_MODE: filter_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (face_size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (face_size_ff > SIZE_W'(MAX_FACE_SIZE)) begin
         size_eff = SIZE_W'(MAX_FACE_SIZE);
      end else begin
         size_eff = face_size_ff;
      end
   end

   ctam_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .size       (size_eff),
      .bil        (filter_mode_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (push_full)
   );

   ctam_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (push_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   ctam_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> tb/cubemap_texel_address_checker.sv
`timescale 1ns / 1ps
module cubemap_texel_address_checker (
   input  logic                          clock,
   input  logic                          reset,
   ctam_req_if                           req_mon,
   ctam_rsp_if                           rsp_mon,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [ctam_pkg::SIZE_W-1:0]   csr_write_data,
   output int                            failures,
   output int                            pending
);
   import ctam_pkg::*;

   typedef struct {
      face_type           face;
      logic [COORD_W-1:0] x_low;
      logic [COORD_W-1:0] y_low;
      logic [COORD_W-1:0] x_high;
      logic [COORD_W-1:0] y_high;
      logic [FRAC_W-1:0]  frac_x;
      logic [FRAC_W-1:0]  frac_y;
      logic [ADDR_W-1:0]  addr_ll;
      logic [ADDR_W-1:0]  addr_hl;
      logic [ADDR_W-1:0]  addr_lh;
      logic [ADDR_W-1:0]  addr_hh;
   } texel_addr_type;

   logic [SIZE_W-1:0] cur_size;
   logic              cur_bilinear;
   texel_addr_type    expected_addrs[$];

   function automatic void face_axis(input longint minor, input longint major,
                                     input longint size, input bit bil,
                                     output longint lo, output longint hi,
                                     output longint frac);
      longint n;
      longint den;
      longint top;
      longint num;
      n    = minor + major;
      den  = 2 * major;
      top  = size - 1;
      frac = 0;
      if (!bil) begin
         lo = (n * size) / den;
         if (lo > top) lo = top;
         hi = lo;
         return;
      end
      if (n * size <= major) begin
         lo = 0;
      end else begin
         num = n * size - major;
         if (num / den >= top) begin
            lo = top;
         end else begin
            lo   = num / den;
            frac = ((num % den) * 256) / den;
         end
      end
      hi = (lo + 1 > top) ? top : lo + 1;
   endfunction

   function automatic logic [ADDR_W-1:0] element_index(longint f, longint size, longint x,
                                                       longint y);
      return ADDR_W'((f * size * size + y * size + x) * COMPONENTS_PER_TEXEL);
   endfunction

   function automatic texel_addr_type lookup_texels(logic signed [DIR_W-1:0] dx,
                                                    logic signed [DIR_W-1:0] dy,
                                                    logic signed [DIR_W-1:0] dz);
      texel_addr_type r;
      longint x, y, z, ax, ay, az, s, t, major, size;
      longint xl, xh, fx, yl, yh, fy;
      x = dx;
      y = dy;
      z = dz;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      size = cur_size;
      if (size == 0) size = 1;
      if (size > MAX_FACE_SIZE) size = MAX_FACE_SIZE;
      if (ax >= ay && ax >= az) begin
         r.face = (x >= 0) ? FACE_POS_X : FACE_NEG_X;
         s = (r.face == FACE_POS_X) ? -z : z;
         t = -y;
         major = ax;
      end else if (ay >= az) begin
         r.face = (y >= 0) ? FACE_POS_Y : FACE_NEG_Y;
         s = x;
         t = (r.face == FACE_POS_Y) ? z : -z;
         major = ay;
      end else begin
         r.face = (z >= 0) ? FACE_POS_Z : FACE_NEG_Z;
         s = (r.face == FACE_POS_Z) ? x : -x;
         t = -y;
         major = az;
      end
      if (major == 0) begin
         s = 0;
         t = 0;
         major = 1;
      end
      face_axis(s, major, size, cur_bilinear, xl, xh, fx);
      face_axis(t, major, size, cur_bilinear, yl, yh, fy);
      r.x_low   = COORD_W'(xl);
      r.y_low   = COORD_W'(yl);
      r.x_high  = COORD_W'(xh);
      r.y_high  = COORD_W'(yh);
      r.frac_x  = FRAC_W'(fx);
      r.frac_y  = FRAC_W'(fy);
      r.addr_ll = element_index(r.face, size, xl, yl);
      r.addr_hl = element_index(r.face, size, xh, yl);
      r.addr_lh = element_index(r.face, size, xl, yh);
      r.addr_hh = element_index(r.face, size, xh, yh);
      return r;
   endfunction

   function automatic int field_mismatch(string name, longint exp_val, longint act_val);
      if (exp_val == act_val) return 0;
      $error("%s expected %0d actual %0d", name, exp_val, act_val);
      return 1;
   endfunction

   always @(posedge clock) begin
      texel_addr_type e;
      int bad;
      if (reset) begin
         cur_size     <= SIZE_W'(256);
         cur_bilinear <= 1'b0;
         expected_addrs.delete();
         failures     <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_FACE_SIZE) cur_size <= csr_write_data;
            else cur_bilinear <= csr_write_data[0];
         end
         if (req_mon.valid && req_mon.ready)
            expected_addrs = {expected_addrs, lookup_texels(req_mon.dir_x, req_mon.dir_y,
                                                            req_mon.dir_z)};
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_addrs.size() == 0) begin
               $error("response transaction with no request outstanding");
               failures <= failures + 1;
            end else begin
               e = expected_addrs.pop_front();
               bad = 0;
               bad += field_mismatch("face", e.face, rsp_mon.face);
               bad += field_mismatch("x_low", e.x_low, rsp_mon.x_low);
               bad += field_mismatch("y_low", e.y_low, rsp_mon.y_low);
               bad += field_mismatch("x_high", e.x_high, rsp_mon.x_high);
               bad += field_mismatch("y_high", e.y_high, rsp_mon.y_high);
               bad += field_mismatch("frac_x", e.frac_x, rsp_mon.frac_x);
               bad += field_mismatch("frac_y", e.frac_y, rsp_mon.frac_y);
               bad += field_mismatch("addr_ll", e.addr_ll, rsp_mon.addr_ll);
               bad += field_mismatch("addr_hl", e.addr_hl, rsp_mon.addr_hl);
               bad += field_mismatch("addr_lh", e.addr_lh, rsp_mon.addr_lh);
               bad += field_mismatch("addr_hh", e.addr_hh, rsp_mon.addr_hh);
               if (bad != 0) failures <= failures + 1;
            end
         end
      end
   end

   assign pending = expected_addrs.size();

endmodule

>>> tb/cubemap_texel_address_unit_tb.sv
`timescale 1ns / 1ps
module cubemap_texel_address_unit_tb;
   import ctam_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic              csr_index = CSR_FACE_SIZE;
   logic [SIZE_W-1:0] csr_write_data = '0;
   int                failures;
   int                pending;
   int                cycle_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_idle_pct = 0;
   int                hold_off_cycles = 0;
   logic              req_taken = 1'b0;

   ctam_req_if req_chan ();
   ctam_rsp_if rsp_chan ();

   cubemap_texel_address_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cubemap_texel_address_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending          (pending)
   );

   always #6 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.dir_x = '0;
      req_chan.dir_y = '0;
      req_chan.dir_z = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
      cycle_count <= cycle_count + 1;
      if (cycle_count > 300000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_chan.ready = 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_chan.ready = !reset && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_direction(input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] z);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.dir_x = x;
      req_chan.dir_y = y;
      req_chan.dir_z = z;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic drain_and_write(input logic idx, input logic [SIZE_W-1:0] value);
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [15:0] random_component(int shape);
      case (shape)
         0: return 16'($urandom_range(65535));
         1: return 16'($signed($urandom_range(64)) - 32);
         default: return $urandom_range(1) ? 16'h8000 + 16'($urandom_range(3))
                                            : 16'h7fff - 16'($urandom_range(3));
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [15:0] c[3];
      int shape;
      int m;
      repeat (count) begin
         shape = $urandom_range(9);
         foreach (c[i]) c[i] = random_component(shape < 6 ? 0 : (shape < 8 ? 1 : 2));
         if (shape == 9) begin
            m = $urandom_range(2);
            c[(m + 1) % 3] = $urandom_range(1) ? c[m] : -c[m];
         end
         send_direction(c[0], c[1], c[2]);
      end
   endtask

   logic [15:0] directed_vecs[18][3] = '{
      '{16'sd0, 16'sd0, 16'sd0},            '{16'sd32767, 16'sd0, 16'sd0},
      '{-16'sd32768, 16'sd0, 16'sd0},       '{16'sd0, 16'sd32767, 16'sd0},
      '{16'sd0, -16'sd32768, 16'sd0},       '{16'sd0, 16'sd0, 16'sd32767},
      '{16'sd0, 16'sd0, -16'sd32768},       '{16'sd100, 16'sd100, 16'sd100},
      '{-16'sd5, 16'sd7, -16'sd7},          '{16'sd0, -16'sd9, 16'sd9},
      '{-16'sd32768, -16'sd32768, -16'sd32768}, '{16'sd32767, -16'sd32768, 16'sd32767},
      '{16'sd1, 16'sd0, 16'sd0},            '{-16'sd1, 16'sd1, -16'sd1},
      '{16'sd16384, 16'sd16383, -16'sd16384}, '{-16'sd32768, 16'sd32767, -16'sd32767},
      '{16'sd5, -16'sd32768, 16'sd32767},   '{16'sd0, 16'sd0, -16'sd1}
   };

   logic [SIZE_W-1:0] size_list[9] = '{13'd256, 13'd1, 13'd4096, 13'd0, 13'd8191,
                                       13'd3, 13'd4097, 13'd17, 13'd64};
   logic              mode_list[9] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                                       1'b1, 1'b0};

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int k = 0; k < 9; k++) begin
         if (k < 3) begin
            sender_idle_pct   = 37;
            receiver_idle_pct = 82;
         end else if (k < 6) begin
            sender_idle_pct   = 82;
            receiver_idle_pct = 37;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         drain_and_write(CSR_FACE_SIZE, size_list[k]);
         drain_and_write(CSR_FILTER_MODE, SIZE_W'(mode_list[k]));
         foreach (directed_vecs[i])
            send_direction(directed_vecs[i][0], directed_vecs[i][1], directed_vecs[i][2]);
         if (k == 7) begin
            hold_off_cycles = 400;
            sender_idle_pct = 0;
            send_random(60);
         end
         send_random(160);
      end
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
